>>> src/sdmr_pkg.sv
// shared types, codes and constants for the sensor-driven motor speed ramp
// no dependencies; imported by sdmr_calc, the top level and the checker
package sdmr_pkg;

  // tuning constants
  localparam int RAMP_STEP     = 5;
  localparam int TEMP_GAIN     = 10;
  localparam int DIST_GAIN     = 10;
  localparam int CUT_EIGHTH    = 3;
  localparam int CUT_SIXTEENTH = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_RAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SLOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN      = 3'd7;

  // motor modes
  localparam logic [1:0] MODE_STOP     = 2'd0;
  localparam logic [1:0] MODE_FORWARD  = 2'd1;
  localparam logic [1:0] MODE_BACKWARD = 2'd2;

  // h-bridge levels m1in1,m1in2,m2in1,m2in2 from bit 3 down
  localparam logic [3:0] PINS_FORWARD  = 4'hA;
  localparam logic [3:0] PINS_BACKWARD = 4'h5;

  // line patterns
  localparam logic [2:0] PAT_BACKWARD        = 3'd0;
  localparam logic [2:0] PAT_RIGHT_EIGHTH    = 3'd1;
  localparam logic [2:0] PAT_RIGHT_SIXTEENTH = 3'd3;
  localparam logic [2:0] PAT_LEFT_EIGHTH     = 3'd4;
  localparam logic [2:0] PAT_STOP            = 3'd5;
  localparam logic [2:0] PAT_LEFT_SIXTEENTH  = 3'd6;

  typedef struct packed {
    logic signed [7:0] temp_low;
    logic signed [7:0] temp_mid;
    logic signed [7:0] temp_high;
    logic [6:0]        humidity_rain;
    logic [9:0]        distance_min;
    logic [9:0]        distance_slow;
    logic [7:0]        duty_max;
    logic [7:0]        duty_min;
  } cfg_t;

  // packed so that temperature lands in the lowest bits of tdata
  typedef struct packed {
    logic [2:0]        pad;
    logic [2:0]        line_pattern;
    logic              sensor_fail;
    logic [9:0]        distance;
    logic [6:0]        humidity;
    logic signed [7:0] temperature;
  } in_t;

  typedef struct packed {
    logic [1:0] pad;
    logic [1:0] motor_mode;
    logic [3:0] bridge_pins;
    logic [7:0] duty_right;
    logic [7:0] duty_left;
  } out_t;

  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic [3:0] pin_levels;
    logic [1:0] mode;
  } state_t;

endpackage

>>> src/sdmr_calc.sv
// per-tick datapath: speed target, ramp and clamp, line-pattern steering
// depends on sdmr_pkg
module sdmr_calc (
  input  sdmr_pkg::in_t    item,
  input  sdmr_pkg::cfg_t   cfg,
  input  sdmr_pkg::state_t st,
  output sdmr_pkg::state_t st_next,
  output sdmr_pkg::out_t   res
);
  import sdmr_pkg::*;

  function automatic logic [7:0] ramp(input logic [7:0] cur,
                                      input logic signed [15:0] tgt,
                                      input logic [7:0] dmin,
                                      input logic [7:0] dmax);
    logic signed [15:0] v;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    v  = signed'({8'b0, cur});
    lo = signed'({8'b0, dmin});
    hi = signed'({8'b0, dmax});
    if (v < tgt) begin
      v = v + signed'(16'(RAMP_STEP));
    end else if (v > tgt) begin
      v = v - signed'(16'(RAMP_STEP));
    end
    // with inverted limits a value below the lower bound takes that bound, any other the upper bound
    if (v < lo) begin
      v = lo;
    end else if (v > hi) begin
      v = hi;
    end
    return v[7:0];
  endfunction

  logic signed [15:0] temp_ext;
  logic signed [15:0] target;
  logic [9:0]         dist_gap;
  logic signed [15:0] dist_pen;
  logic [7:0]         d1;
  logic [7:0]         d2;

  always_comb begin
    temp_ext = 16'(item.temperature);
    dist_gap = cfg.distance_slow - item.distance;
    dist_pen = signed'({6'b0, dist_gap}) * signed'(16'(DIST_GAIN));

    if (item.temperature > cfg.temp_low && item.temperature < cfg.temp_mid) begin
      target = temp_ext * signed'(16'(TEMP_GAIN));
    end else if (item.temperature > cfg.temp_mid && item.temperature < cfg.temp_high) begin
      target = signed'({8'b0, cfg.duty_max});
    end else begin
      target = signed'({8'b0, cfg.duty_min});
    end

    // rain halving rounds toward minus infinity
    if (item.humidity > cfg.humidity_rain) begin
      target = target >>> 1;
    end

    if (item.distance > cfg.distance_min && item.distance < cfg.distance_slow) begin
      target = target - dist_pen;
    end else if (!(item.distance > cfg.distance_slow)) begin
      target = signed'({8'b0, cfg.duty_min});
    end

    if (item.sensor_fail) begin
      target = '0;
    end

    d1 = ramp(st.duty_one, target, cfg.duty_min, cfg.duty_max);
    d2 = ramp(st.duty_two, target, cfg.duty_min, cfg.duty_max);

    st_next.duty_one   = d1;
    st_next.duty_two   = d2;
    st_next.pin_levels = PINS_FORWARD;
    st_next.mode       = MODE_FORWARD;

    unique case (item.line_pattern)
      PAT_BACKWARD: begin
        st_next.pin_levels = PINS_BACKWARD;
        st_next.mode       = MODE_BACKWARD;
      end
      PAT_RIGHT_EIGHTH:    st_next.duty_two = d2 - (d2 >> CUT_EIGHTH);
      PAT_RIGHT_SIXTEENTH: st_next.duty_two = d2 - (d2 >> CUT_SIXTEENTH);
      PAT_LEFT_EIGHTH:     st_next.duty_one = d1 - (d1 >> CUT_EIGHTH);
      PAT_LEFT_SIXTEENTH:  st_next.duty_one = d1 - (d1 >> CUT_SIXTEENTH);
      PAT_STOP: begin
        // pins hold their previous level in stop
        st_next.pin_levels = st.pin_levels;
        st_next.mode       = MODE_STOP;
      end
      default: ;
    endcase

    res.pad         = '0;
    res.motor_mode  = st_next.mode;
    res.bridge_pins = st_next.pin_levels;
    res.duty_left   = (st_next.mode == MODE_STOP) ? 8'd0 : st_next.duty_one;
    res.duty_right  = (st_next.mode == MODE_STOP) ? 8'd0 : st_next.duty_two;
  end

endmodule

>>> src/sensor_driven_motor_speed_ramp_top.sv
// Sensor-driven motor speed ramp. Takes one sensor beat per cycle while results are taken (a
// new beat can be accepted every clock) and returns one result beat per input beat. The
// accepting edge loads the input register; the beat then passes through the datapath into
// the result register, which drives m_tvalid. A result that waits
// on m_tready holds the input register; with both registers full s_tready drops until
// the result is taken. The stored duties, pin levels and mode are updated in the same
// cycle the result is registered, so consecutive beats chain through those registers at
// full rate. Configuration writes take effect on the next clock and must be made while
// no beat is in flight. Stop returns zero duties but keeps the ramped duties stored.
// top level; depends on sdmr_pkg and sdmr_calc
module sensor_driven_motor_speed_ramp_top (
  input  logic                            clk,
  input  logic                            rst,
  // temperature, humidity, distance, sensor_fail, line_pattern from bit 0 up
  input  logic [sdmr_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // duty_left, duty_right, bridge_pins, motor_mode from bit 0 up
  output logic [sdmr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [sdmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdmr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdmr_pkg::*;

  cfg_t   cfg;
  in_t    in_q;
  logic   in_valid;
  out_t   out_q;
  logic   out_valid;
  state_t st;
  state_t st_next;
  out_t   res;
  logic   advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_low      <= 8'sd0;
      cfg.temp_mid      <= 8'sd25;
      cfg.temp_high     <= 8'sd50;
      cfg.humidity_rain <= 7'd80;
      cfg.distance_min  <= 10'd10;
      cfg.distance_slow <= 10'd30;
      cfg.duty_max      <= 8'd255;
      cfg.duty_min      <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_LOW:      cfg.temp_low      <= cfg_data[7:0];
        REG_TEMP_MID:      cfg.temp_mid      <= cfg_data[7:0];
        REG_TEMP_HIGH:     cfg.temp_high     <= cfg_data[7:0];
        REG_HUMIDITY_RAIN: cfg.humidity_rain <= cfg_data[6:0];
        REG_DISTANCE_MIN:  cfg.distance_min  <= cfg_data;
        REG_DISTANCE_SLOW: cfg.distance_slow <= cfg_data;
        REG_DUTY_MAX:      cfg.duty_max      <= cfg_data[7:0];
        REG_DUTY_MIN:      cfg.duty_min      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= s_tdata;
    end
  end

  sdmr_calc u_calc (
    .item    (in_q),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // stored duties and bridge state move with each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st.duty_one   <= '0;
      st.duty_two   <= '0;
      st.pin_levels <= '0;
      st.mode       <= MODE_STOP;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

>>> src/sdmr_checker.sv
// port-level checks for the motor speed ramp, bound to the top level
// depends on sdmr_pkg
module sdmr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [sdmr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import sdmr_pkg::*;

  out_t o;
  assign o = m_tdata;

  // stop drives both duties to zero
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o.motor_mode == MODE_STOP |-> o.duty_left == 8'd0 && o.duty_right == 8'd0)
    else $error("stop beat with nonzero duty");

  // pin levels agree with the driving direction
  a_pins_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o.motor_mode != MODE_STOP |->
      (o.motor_mode == MODE_FORWARD && o.bridge_pins == PINS_FORWARD) ||
      (o.motor_mode == MODE_BACKWARD && o.bridge_pins == PINS_BACKWARD))
    else $error("bridge pins disagree with mode");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

endmodule

bind sensor_driven_motor_speed_ramp_top sdmr_checker u_sdmr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
